FILE: src/pisc_pkg.sv
// ----------------------------------------------------------------------------
// pisc_pkg: shared types and constants for the PID integral separation block
// Register map, configuration bundle and datapath widths.
// ----------------------------------------------------------------------------
package pisc_pkg;

  localparam int CFG_AW = 5;   // five 32-bit registers at 4-byte spacing
  localparam int CFG_DW = 32;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 17;
  localparam int DERIV_W   = 18;
  localparam int INTEG_W   = 31;  // clamped integral fits +/-(2^30-1)
  localparam int SUM_STATE_W = 32;
  localparam int IBOUND_W  = 30;
  localparam int SBOUND_W  = 17;
  localparam int DRIVE_W   = 32;

  localparam logic [IBOUND_W-1:0] IBOUND_RST = '1;
  localparam logic [SBOUND_W-1:0] SBOUND_RST = '1;

  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_IBOUND = 3'd3,
    REG_SBOUND = 3'd4
  } pisc_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]   kp;
    logic signed [GAIN_W-1:0]   ki;
    logic signed [GAIN_W-1:0]   kd;
    logic        [IBOUND_W-1:0] int_bound;
    logic        [SBOUND_W-1:0] sep_bound;
  } pisc_cfg_t;

endpackage

FILE: src/pisc_regs.sv
// ----------------------------------------------------------------------------
// pisc_regs: APB register file
// Holds gains and bounds; writes land on the access phase, reads decode live.
// ----------------------------------------------------------------------------
module pisc_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pisc_pkg::CFG_AW-1:0] paddr,
  input  logic [pisc_pkg::CFG_DW-1:0] pwdata,
  output logic [pisc_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output pisc_pkg::pisc_cfg_t       cfg
);
  import pisc_pkg::*;

  pisc_cfg_t cfg_r;
  pisc_cfg_t cfg_nxt;
  pisc_reg_t reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = pisc_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_KP:     cfg_nxt.kp        = pwdata[GAIN_W-1:0];
        REG_KI:     cfg_nxt.ki        = pwdata[GAIN_W-1:0];
        REG_KD:     cfg_nxt.kd        = pwdata[GAIN_W-1:0];
        REG_IBOUND: cfg_nxt.int_bound = pwdata[IBOUND_W-1:0];
        REG_SBOUND: cfg_nxt.sep_bound = pwdata[SBOUND_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= '0;
      cfg_r.ki        <= '0;
      cfg_r.kd        <= '0;
      cfg_r.int_bound <= IBOUND_RST;
      cfg_r.sep_bound <= SBOUND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KP:     prdata = {{(CFG_DW-GAIN_W){cfg_r.kp[GAIN_W-1]}}, cfg_r.kp};
      REG_KI:     prdata = {{(CFG_DW-GAIN_W){cfg_r.ki[GAIN_W-1]}}, cfg_r.ki};
      REG_KD:     prdata = {{(CFG_DW-GAIN_W){cfg_r.kd[GAIN_W-1]}}, cfg_r.kd};
      REG_IBOUND: prdata = {{(CFG_DW-IBOUND_W){1'b0}}, cfg_r.int_bound};
      REG_SBOUND: prdata = {{(CFG_DW-SBOUND_W){1'b0}}, cfg_r.sep_bound};
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: src/pid_integral_separation_clamp.sv
// ----------------------------------------------------------------------------
// pid_integral_separation_clamp: fixed-point PID with integral separation
// Pipeline: input register (loads at the accepting edge), then error, product
//   and output registers ahead of out_tvalid. Throughput: one transaction per
//   cycle while out_tready does not stall the output, set by the integral
//   update (add, separation test, clamp) completed within the error stage.
// Reset (synchronous, rst_n low): pipeline empty, integral and previous error
//   zero, gains zero, integral bound 2^30-1, separation bound 131071.
// ----------------------------------------------------------------------------
module pid_integral_separation_clamp (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [15:0] target_value, [31:16] sensed_value
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // [31:0] drive_value
  output logic [0:0]                  out_tuser,  // [0] drive_saturated
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pisc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pisc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pisc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import pisc_pkg::*;

  localparam int PROP_W = GAIN_W + ERR_W;
  localparam int IPROD_W = GAIN_W + INTEG_W;
  localparam int DPROD_W = GAIN_W + DERIV_W;
  localparam int ACC_W   = IPROD_W + 2;    // room for the three-way sum
  localparam int SHR_W   = ACC_W - 8;      // after dropping the Q8.8 fraction

  pisc_cfg_t cfg;

  pisc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Per-stage handshake: a stage loads when it is empty or its contents move on.
  // This lets a new transaction enter while a finished result is still waiting.
  logic s0_vld_r, s1_vld_r, s2_vld_r, out_vld_r;
  logic s0_rdy, s1_rdy, s2_rdy, out_rdy;

  assign out_rdy   = !out_vld_r || out_tready;
  assign s2_rdy    = !s2_vld_r  || out_rdy;
  assign s1_rdy    = !s1_vld_r  || s2_rdy;
  assign s0_rdy    = !s0_vld_r  || s1_rdy;
  assign in_tready = s0_rdy;

  logic in_take, s0_move, s1_move, s2_move;
  assign in_take = in_tvalid && s0_rdy;
  assign s0_move = s0_vld_r && s1_rdy;
  assign s1_move = s1_vld_r && s2_rdy;
  assign s2_move = s2_vld_r && out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s0_rdy)  s0_vld_r  <= in_tvalid;
      if (s1_rdy)  s1_vld_r  <= s0_vld_r;
      if (s2_rdy)  s2_vld_r  <= s1_vld_r;
      if (out_rdy) out_vld_r <= s2_vld_r;
    end
  end

  // Stage 0: capture the samples.
  logic signed [SAMPLE_W-1:0] tgt_r, sen_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      tgt_r <= in_tdata[SAMPLE_W-1:0];
      sen_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  // Stage 1: error, integral update with separation and clamp, derivative.
  // The integral and previous error advance only when a transaction leaves
  // stage 0, so each sample sees exactly the state its predecessor left.
  logic signed [SUM_STATE_W-1:0] error_sum_r, error_sum_nxt;
  logic signed [ERR_W-1:0]       last_error_r;

  logic signed [ERR_W-1:0]   err;
  logic        [ERR_W-1:0]   err_mag;
  logic                      sep_hit;
  logic signed [SUM_STATE_W:0] acc_sum, acc_sel, bound_pos, bound_neg, integ_full;
  logic signed [DERIV_W-1:0] deriv;

  always_comb begin
    err       = {tgt_r[SAMPLE_W-1], tgt_r} - {sen_r[SAMPLE_W-1], sen_r};
    err_mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    sep_hit   = err_mag > cfg.sep_bound;
    acc_sum   = {error_sum_r[SUM_STATE_W-1], error_sum_r}
              + {{(SUM_STATE_W+1-ERR_W){err[ERR_W-1]}}, err};
    acc_sel   = sep_hit ? '0 : acc_sum;
    bound_pos = {{(SUM_STATE_W+1-IBOUND_W){1'b0}}, cfg.int_bound};
    bound_neg = -bound_pos;
    if (acc_sel > bound_pos) begin
      integ_full = bound_pos;
    end else if (acc_sel < bound_neg) begin
      integ_full = bound_neg;
    end else begin
      integ_full = acc_sel;
    end
    error_sum_nxt = integ_full[SUM_STATE_W-1:0];
    deriv = {err[ERR_W-1], err} - {last_error_r[ERR_W-1], last_error_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (s0_move) begin
      error_sum_r  <= error_sum_nxt;
      last_error_r <= err;
    end
  end

  logic signed [ERR_W-1:0]   err_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [DERIV_W-1:0] deriv_r;

  always_ff @(posedge clk) begin
    if (s0_move) begin
      err_r   <= err;
      integ_r <= integ_full[INTEG_W-1:0];
      deriv_r <= deriv;
    end
  end

  // Stage 2: the three gain products, each exact.
  logic signed [GAIN_W-1:0]  kp_s, ki_s, kd_s;
  logic signed [PROP_W-1:0]  prop_nxt, prop_r;
  logic signed [IPROD_W-1:0] iprod_nxt, iprod_r;
  logic signed [DPROD_W-1:0] dprod_nxt, dprod_r;

  assign kp_s      = cfg.kp;
  assign ki_s      = cfg.ki;
  assign kd_s      = cfg.kd;
  assign prop_nxt  = kp_s * err_r;
  assign iprod_nxt = ki_s * integ_r;
  assign dprod_nxt = kd_s * deriv_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      prop_r  <= prop_nxt;
      iprod_r <= iprod_nxt;
      dprod_r <= dprod_nxt;
    end
  end

  // Stage 3: sum, floor shift by 8, saturate to 32 bits.
  logic signed [ACC_W-1:0] acc;
  logic signed [SHR_W-1:0] shr;
  logic                    ovf_hi, ovf_lo;
  logic [DRIVE_W-1:0]      drive_nxt;
  logic                    sat_nxt;
  logic [DRIVE_W-1:0]      drive_r;
  logic                    sat_r;

  always_comb begin
    acc    = ACC_W'(prop_r) + ACC_W'(iprod_r) + ACC_W'(dprod_r);
    shr    = acc[ACC_W-1:8];   // arithmetic drop of the fraction rounds toward -inf
    ovf_hi = !shr[SHR_W-1] && (|shr[SHR_W-2:DRIVE_W-1]);
    ovf_lo =  shr[SHR_W-1] && !(&shr[SHR_W-2:DRIVE_W-1]);
    if (ovf_hi) begin
      drive_nxt = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (ovf_lo) begin
      drive_nxt = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_nxt = shr[DRIVE_W-1:0];
    end
    sat_nxt = ovf_hi || ovf_lo;
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = drive_r;
  assign out_tuser[0] = sat_r;

  // Integral state never leaves the widest clamp range.
  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (error_sum_r <= $signed({2'b00, {IBOUND_W{1'b1}}})) &&
    (error_sum_r >= -$signed({2'b00, {IBOUND_W{1'b1}}})))
    else $error("integral state outside clamp range");

  // A saturated result carries one of the two rail values.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && sat_r |->
      (drive_r == {1'b0, {(DRIVE_W-1){1'b1}}}) || (drive_r == {1'b1, {(DRIVE_W-1){1'b0}}}))
    else $error("saturated result not at a rail");

  // Input backpressure only when every stage holds a transaction.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s0_vld_r && s1_vld_r && s2_vld_r && out_vld_r)
    else $error("input stalled with a free stage");

  // State advances only together with a transaction leaving the input register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s0_move |=> $stable(error_sum_r) && $stable(last_error_r))
    else $error("controller state changed without a transaction");

endmodule

FILE: sim/pid_integral_separation_clamp_tb.sv
// ----------------------------------------------------------------------------
// pid_integral_separation_clamp_tb: self-checking bench for the PID block
// Drives sample transactions and random register settings. A local PID
// predictor forms the expected drive value and saturation flag of every
// accepted sample. Each result transaction is compared in order against
// those expectations, under random idling on both streams.
// ----------------------------------------------------------------------------
module pid_integral_separation_clamp_tb;
  import pisc_pkg::*;

  localparam int     RANDOM_ITEMS = 1900;
  localparam int     WINDUP_LEN   = 300;
  localparam int     HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int     HOLD_AT      = 40;   // results seen before the hold-off
  localparam int     SETTLE_CYC   = 8;    // pipeline is 4 deep
  localparam int     SHOW_MAX     = 10;
  localparam longint DRIVE_MAX    = (longint'(1) <<< (DRIVE_W - 1)) - 1;
  localparam longint DRIVE_MIN    = -(longint'(1) <<< (DRIVE_W - 1));

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      sat;
  } drive_t;

  // one line of the directed plan: a register setting or a sample
  typedef struct {
    bit                         is_cfg;
    pisc_cfg_t                  cfg;
    logic signed [SAMPLE_W-1:0] tgt;
    logic signed [SAMPLE_W-1:0] sns;
    bit                         fixed;
    drive_t                     want;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;   // [15:0] target_value, [31:16] sensed_value
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;  // [31:0] drive_value
  logic [0:0]          out_tuser;  // [0] drive_saturated
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // predictor state: register copy, integral and previous error
  pisc_cfg_t                     cfg_q;
  logic signed [SUM_STATE_W-1:0] integ_acc;
  logic signed [ERR_W-1:0]       prev_err;

  drive_t      pending_drive[$];
  plan_row_t   plan_q[$];
  int unsigned samples_in;
  int unsigned samples_out;
  int unsigned mismatches;
  bit          send_rush;

  pid_integral_separation_clamp u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the PID state by one sample and return the expected result.
  // Error, integral and derivative are plain integers, gains are Q8.8; the
  // sum is exact in 64 bits, then floored by the shift and clipped.
  function automatic drive_t next_drive(input logic signed [SAMPLE_W-1:0] tgt,
                                        input logic signed [SAMPLE_W-1:0] sns);
    longint err;
    longint mag;
    longint integ;
    longint deriv;
    longint acc;
    longint y;
    drive_t r;
    err   = longint'(tgt) - longint'(sns);
    mag   = (err < 0) ? -err : err;
    integ = longint'(integ_acc) + err;
    // separation: only a magnitude strictly above the bound clears
    if (mag > longint'(cfg_q.sep_bound)) integ = 0;
    if (integ > longint'(cfg_q.int_bound)) integ = longint'(cfg_q.int_bound);
    else if (integ < -longint'(cfg_q.int_bound)) integ = -longint'(cfg_q.int_bound);
    integ_acc = SUM_STATE_W'(integ);
    deriv     = err - longint'(prev_err);
    prev_err  = ERR_W'(err);
    acc = longint'($signed(cfg_q.kp)) * err + longint'($signed(cfg_q.ki)) * integ
        + longint'($signed(cfg_q.kd)) * deriv;
    y = acc >>> 8;
    r.sat = 1'b0;
    if (y > DRIVE_MAX) begin
      y = DRIVE_MAX;
      r.sat = 1'b1;
    end else if (y < DRIVE_MIN) begin
      y = DRIVE_MIN;
      r.sat = 1'b1;
    end
    r.drive = DRIVE_W'(y);
    return r;
  endfunction

  function automatic pisc_cfg_t make_cfg(input int kp, input int ki, input int kd,
                                         input longint ib, input int sb);
    pisc_cfg_t c;
    c.kp        = GAIN_W'(kp);
    c.ki        = GAIN_W'(ki);
    c.kd        = GAIN_W'(kd);
    c.int_bound = IBOUND_W'(ib);
    c.sep_bound = SBOUND_W'(sb);
    return c;
  endfunction

  function automatic void plan_cfg(input int kp, input int ki, input int kd,
                                   input longint ib, input int sb);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg    = make_cfg(kp, ki, kd, ib, sb);
    plan_q.push_back(row);
  endfunction

  // A sample row; with fixed set, the given result replaces the prediction.
  function automatic void plan_item(input int tgt, input int sns, input bit fixed = 1'b0,
                                    input longint drive = 0, input bit sat = 1'b0);
    plan_row_t row;
    row            = '{default: '0};
    row.tgt        = SAMPLE_W'(tgt);
    row.sns        = SAMPLE_W'(sns);
    row.fixed      = fixed;
    row.want.drive = DRIVE_W'(drive);
    row.want.sat   = sat;
    plan_q.push_back(row);
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return GAIN_W'(int'($urandom_range(0, 1023)) - 512);
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  function automatic pisc_cfg_t draw_cfg();
    pisc_cfg_t c;
    c.kp = pick_gain();
    c.ki = pick_gain();
    c.kd = pick_gain();
    case ($urandom_range(0, 3))
      0:       c.int_bound = '0;
      1:       c.int_bound = '1;
      2:       c.int_bound = IBOUND_W'($urandom_range(0, 5000));
      default: c.int_bound = IBOUND_W'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0:       c.sep_bound = '0;
      1:       c.sep_bound = '1;
      2:       c.sep_bound = SBOUND_W'($urandom_range(0, 300));
      3:       c.sep_bound = SBOUND_W'($urandom_range(0, 70000));
      default: c.sep_bound = SBOUND_W'($urandom());
    endcase
    return c;
  endfunction

  // Mostly errors near the separation bound or small tracking errors,
  // the rest fully random pairs.
  function automatic void draw_sample(output logic signed [SAMPLE_W-1:0] tgt,
                                      output logic signed [SAMPLE_W-1:0] sns);
    int t;
    int s;
    int d;
    t = int'($signed(SAMPLE_W'($urandom())));
    d = 0;
    case ($urandom_range(0, 3))
      0:       s = int'($signed(SAMPLE_W'($urandom())));
      1:       d = int'(cfg_q.sep_bound) + int'($urandom_range(0, 2)) - 1;
      2:       d = $urandom_range(0, 64);
      default: d = $urandom_range(0, 3000);
    endcase
    if (d != 0) begin
      if ($urandom_range(0, 1) == 1) d = -d;
      s = t - d;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
    end else if (s == 0) begin
      s = t;
    end
    tgt = SAMPLE_W'(t);
    sns = SAMPLE_W'(s);
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Offer one sample after a random gap and wait for its transaction.
  // Keep tvalid high across back-to-back samples; lower it only for a gap.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] tgt,
                             input logic signed [SAMPLE_W-1:0] sns,
                             input bit fixed = 1'b0, input drive_t want = '0);
    int unsigned gap;
    drive_t      pred;
    if ($urandom_range(0, 39) == 0) send_rush = !send_rush;
    gap = send_rush ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sns, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // accepted at this edge: advance the predictor in acceptance order
    pred = next_drive(tgt, sns);
    pending_drive.push_back(fixed ? want : pred);
    samples_in++;
  endtask

  // Drop tvalid and wait until every expected result has come out.
  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write all five registers, setup then access phase each; keep psel high
  // between writes so that no signal is assigned twice in one step.
  task automatic load_regs(input pisc_cfg_t c);
    pisc_reg_t   r;
    logic [31:0] val;
    r = r.first();
    repeat (r.num()) begin
      case (r)
        REG_KP:     val = {{16{c.kp[GAIN_W-1]}}, c.kp};
        REG_KI:     val = {{16{c.ki[GAIN_W-1]}}, c.ki};
        REG_KD:     val = {{16{c.kd[GAIN_W-1]}}, c.kd};
        REG_IBOUND: val = 32'(c.int_bound);
        default:    val = 32'(c.sep_bound);
      endcase
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= CFG_AW'({r, 2'b00});
      cfg_pwdata  <= val;
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      r = r.next();
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_q = c;
  endtask

  // Stimulus: reset, directed plan, then random phases.
  initial begin : run_stimulus
    logic signed [SAMPLE_W-1:0] tgt;
    logic signed [SAMPLE_W-1:0] sns;
    pisc_cfg_t                  c;
    int unsigned                phase;
    int unsigned                n;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    cfg_q       = make_cfg(0, 0, 0, IBOUND_RST, SBOUND_RST);
    integ_acc   = '0;
    prev_err    = '0;
    samples_in  = 0;
    mismatches  = 0;
    send_rush   = 1'b0;

    // gains are zero after reset, so the drive is zero for any error
    plan_item(32767, -32768, 1'b1, 0, 1'b0);
    plan_item(-32768, 32767, 1'b1, 0, 1'b0);
    plan_item(0, 0, 1'b1, 0, 1'b0);
    // extreme gains; an error exactly at the separation bound keeps the
    // integral, one past it clears
    plan_cfg(32767, -32768, 32767, IBOUND_RST, 100);
    plan_item(100, 0);
    plan_item(-101, 0);
    plan_item(32767, -32768);
    plan_item(5, 5);
    // zero integral bound pins the integral at zero
    plan_cfg(-32768, 32767, -32768, 0, SBOUND_RST);
    plan_item(1000, 0);
    plan_item(-1000, 0);
    // zero separation bound clears on any nonzero error
    plan_cfg(0, 256, 0, 50, 0);
    plan_item(30, 0);
    plan_item(0, 0);
    plan_item(-40, 10);
    // small integral bound, both clamp directions
    plan_cfg(256, 256, 256, 50, SBOUND_RST);
    plan_item(30, 0);
    plan_item(30, 0);
    plan_item(-80, 0);
    plan_item(-100, 0);
    // separation bound at the largest error magnitude
    plan_cfg(1, 32767, -1, IBOUND_RST, 65535);
    plan_item(32767, -32768);
    plan_item(-32768, 32767);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        settle_pipeline();
        load_regs(plan_q[i].cfg);
      end else begin
        push_sample(plan_q[i].tgt, plan_q[i].sns, plan_q[i].fixed, plan_q[i].want);
      end
    end

    // Random phases. Two of them wind the integral up under a large ki with
    // the separation bound one below the largest error: the first sample
    // clears the integral, the rest add up until the drive saturates,
    // positive in one phase and negative in the other.
    phase = 0;
    while (samples_in < RANDOM_ITEMS) begin
      settle_pipeline();
      if (phase == 2 || phase == 5) begin
        c           = draw_cfg();
        c.ki        = (phase == 2) ? 16'sh7fff : 16'sh8000;
        c.int_bound = '1;
        c.sep_bound = SBOUND_W'(65534);
        load_regs(c);
        push_sample(16'sh7fff, 16'sh8000);
        repeat (WINDUP_LEN) push_sample(16'sh7fff, 16'sh8001);
      end else begin
        load_regs(draw_cfg());
        n = $urandom_range(60, 200);
        repeat (n) begin
          draw_sample(tgt, sns);
          push_sample(tgt, sns);
        end
      end
      phase++;
    end
    settle_pipeline();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random tready gaps, one long hold-off so that the block
  // fills up and stalls its input, and an in-order check of every transaction.
  initial begin : drain_results
    int unsigned gap;
    bit          rush;
    bit          held;
    drive_t      want;
    out_tready  <= 1'b0;
    samples_out = 0;
    rush        = 1'b0;
    held        = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rush = !rush;
      if (!held && samples_out >= HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = rush ? 0 : $urandom_range(0, 19);
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      samples_out++;
      if (pending_drive.size() == 0) begin
        flag_mismatch("result with nothing pending", 0, longint'($signed(out_tdata)));
      end else begin
        want = pending_drive.pop_front();
        if (out_tdata !== want.drive)
          flag_mismatch("drive_value", longint'(want.drive), longint'($signed(out_tdata)));
        if (out_tuser[0] !== want.sat)
          flag_mismatch("drive_saturated", longint'(want.sat), longint'(out_tuser[0]));
      end
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : run_limit
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
src/pisc_pkg.sv
src/pisc_regs.sv
src/pid_integral_separation_clamp.sv
sim/pid_integral_separation_clamp_tb.sv
